// File: rtl/uart_step_pulse_commander_unit_macros.svh
// Assertion macros shared by the step pulse commander RTL.
// Expects clk and rst in the scope of the including module.
`ifndef UART_STEP_PULSE_COMMANDER_UNIT_MACROS_SVH
`define UART_STEP_PULSE_COMMANDER_UNIT_MACROS_SVH

// Check a property that holds in the same cycle.
`define SPC_ASSERT_NOW(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a consequence in the cycle after the antecedent.
`define SPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/spc_pkg.sv
// Types and constants for the step pulse commander.
// No dependencies.
package spc_pkg;

  localparam int unsigned FRAME_BYTES = 9;
  localparam int unsigned STORE_DEPTH = FRAME_BYTES - 1;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_TICK = 1'b1;

  localparam logic [1:0] REPLY_NONE = 2'd0;
  localparam logic [1:0] REPLY_ECHO = 2'd1;
  localparam logic [1:0] REPLY_CW   = 2'd2;
  localparam logic [1:0] REPLY_CCW  = 2'd3;

  localparam logic [15:0] TIMEOUT_RESET    = 16'd1000;
  localparam logic [13:0] STEP_COUNT_RESET = 14'd9;
  localparam logic [13:0] HALF_PERIOD_RESET = 14'd100;

  localparam logic [71:0] PAT_START  = "SSMCSTART";
  localparam logic [71:0] PAT_DIR_CW  = "SSMSETDR-";
  localparam logic [71:0] PAT_DIR_CCW = "SSMSETDR+";
  localparam logic [39:0] PAT_SETSP  = "SETSP";
  localparam logic [39:0] PAT_SETDL  = "SETDL";

  localparam logic [7:0] CHAR_ZERO = "0";
  localparam logic [7:0] CHAR_NINE = "9";

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_START,
    CMD_STEPS,
    CMD_DELAY,
    CMD_CW,
    CMD_CCW
  } cmd_code_t;

  typedef struct packed {
    cmd_code_t   code;
    logic [13:0] value;
  } cmd_t;

  typedef struct packed {
    logic        pin_level;
    logic [1:0]  reply;
    logic        busy;
    logic [13:0] step_setting;
    logic [13:0] delay_setting;
  } res_t;

endpackage

// File: rtl/spc_frame.sv
// Frame assembler: byte store, byte count, receive timeout and command decode.
// Depends on spc_pkg and the assertion macro header.
`include "uart_step_pulse_commander_unit_macros.svh"

module spc_frame
  import spc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        action,
  input  logic [7:0]  rx_byte,
  input  logic        run_active,
  input  logic [15:0] frame_timeout,
  output cmd_t        cmd
);

  localparam logic [3:0] LAST_IDX = 4'(FRAME_BYTES - 1);

  logic [7:0]  frame_store [STORE_DEPTH];
  logic [3:0]  byte_count;
  logic [3:0]  byte_count_next;
  logic [15:0] receive_timer;
  logic [15:0] receive_timer_next;
  logic [15:0] timer_sum;
  logic        take_byte;
  logic        take_tick;
  logic        complete;
  logic [71:0] frame;
  logic        digits_ok;
  logic [13:0] number;

  assign take_byte = step && action == ACT_BYTE && !run_active;
  assign take_tick = step && action == ACT_TICK && !run_active && byte_count != 4'd0;
  assign complete  = take_byte && byte_count == LAST_IDX;
  assign timer_sum = receive_timer + 16'd1;

  always_comb begin
    byte_count_next    = byte_count;
    receive_timer_next = receive_timer;
    if (take_byte) begin
      if (complete) begin
        byte_count_next    = 4'd0;
        receive_timer_next = 16'd0;
      end else begin
        byte_count_next = byte_count + 4'd1;
      end
    end else if (take_tick) begin
      if (timer_sum >= frame_timeout) begin
        byte_count_next    = 4'd0;
        receive_timer_next = 16'd0;
      end else begin
        receive_timer_next = timer_sum;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= 4'd0;
      receive_timer <= 16'd0;
    end else begin
      byte_count    <= byte_count_next;
      receive_timer <= receive_timer_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take_byte && !complete) begin
      frame_store[byte_count[2:0]] <= rx_byte;
    end
  end

  assign frame = {frame_store[0], frame_store[1], frame_store[2], frame_store[3],
                  frame_store[4], frame_store[5], frame_store[6], frame_store[7],
                  rx_byte};

  always_comb begin
    digits_ok = 1'b1;
    for (int i = 0; i < 4; i++) begin
      if (frame[i*8 +: 8] < CHAR_ZERO || frame[i*8 +: 8] > CHAR_NINE) begin
        digits_ok = 1'b0;
      end
    end
  end

  assign number = 14'(frame[27:24]) * 14'd1000 + 14'(frame[19:16]) * 14'd100
                + 14'(frame[11:8]) * 14'd10 + 14'(frame[3:0]);

  always_comb begin
    cmd.code  = CMD_NONE;
    cmd.value = number;
    if (complete) begin
      if (frame == PAT_START) begin
        cmd.code = CMD_START;
      end else if (frame[71:32] == PAT_SETSP) begin
        cmd.code = digits_ok ? CMD_STEPS : CMD_NONE;
      end else if (frame[71:32] == PAT_SETDL) begin
        cmd.code = digits_ok ? CMD_DELAY : CMD_NONE;
      end else if (frame == PAT_DIR_CW) begin
        cmd.code = CMD_CW;
      end else if (frame == PAT_DIR_CCW) begin
        cmd.code = CMD_CCW;
      end
    end
  end

  `SPC_ASSERT_NOW(a_count_range, byte_count <= LAST_IDX, "byte count past frame end")
  `SPC_ASSERT_NOW(a_timer_idle, byte_count != 4'd0 || receive_timer == 16'd0,
                  "receive timer running with no partial frame")

endmodule

// File: rtl/spc_pulse.sv
// Settings, pulse run sequencer and pin driver; builds the result of each item.
// Depends on spc_pkg and the assertion macro header.
`include "uart_step_pulse_commander_unit_macros.svh"

module spc_pulse
  import spc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  logic action,
  input  cmd_t cmd,
  output logic run_active,
  output res_t res
);

  logic [13:0] step_count;
  logic [13:0] step_count_next;
  logic [13:0] half_period;
  logic [13:0] half_period_next;
  logic [13:0] pulses_left;
  logic [13:0] pulses_left_next;
  logic [13:0] phase_timer;
  logic [13:0] phase_timer_next;
  logic        pulse_phase;
  logic        pulse_phase_next;
  logic        pin_state;
  logic        pin_state_next;
  logic [1:0]  reply_next;
  logic [13:0] tick_sum;
  logic [13:0] eff_period;

  assign run_active = pulses_left != 14'd0;
  assign tick_sum   = phase_timer + 14'd1;
  assign eff_period = (half_period == 14'd0) ? 14'd1 : half_period;

  always_comb begin
    step_count_next  = step_count;
    half_period_next = half_period;
    pulses_left_next = pulses_left;
    phase_timer_next = phase_timer;
    pulse_phase_next = pulse_phase;
    pin_state_next   = pin_state;
    reply_next       = REPLY_NONE;
    if (step && action == ACT_TICK && run_active) begin
      if (tick_sum < eff_period) begin
        phase_timer_next = tick_sum;
      end else begin
        phase_timer_next = 14'd0;
        if (!pulse_phase) begin
          pulse_phase_next = 1'b1;
          pin_state_next   = 1'b1;
        end else begin
          pulses_left_next = pulses_left - 14'd1;
          pulse_phase_next = 1'b0;
          if (pulses_left != 14'd1) begin
            pin_state_next = 1'b0;
          end
        end
      end
    end
    unique case (cmd.code)
      CMD_START: begin
        if (step_count != 14'd0) begin
          pulses_left_next = step_count;
          pulse_phase_next = 1'b0;
          phase_timer_next = 14'd0;
          pin_state_next   = 1'b0;
        end
      end
      CMD_STEPS: begin
        step_count_next = cmd.value;
        reply_next      = REPLY_ECHO;
      end
      CMD_DELAY: begin
        half_period_next = cmd.value;
        reply_next       = REPLY_ECHO;
      end
      CMD_CW: begin
        pin_state_next = 1'b1;
        reply_next     = REPLY_CW;
      end
      CMD_CCW: begin
        pin_state_next = 1'b0;
        reply_next     = REPLY_CCW;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_count  <= STEP_COUNT_RESET;
      half_period <= HALF_PERIOD_RESET;
      pulses_left <= 14'd0;
      phase_timer <= 14'd0;
      pulse_phase <= 1'b0;
      pin_state   <= 1'b0;
    end else begin
      step_count  <= step_count_next;
      half_period <= half_period_next;
      pulses_left <= pulses_left_next;
      phase_timer <= phase_timer_next;
      pulse_phase <= pulse_phase_next;
      pin_state   <= pin_state_next;
    end
  end

  assign res.pin_level     = pin_state_next;
  assign res.reply         = reply_next;
  assign res.busy          = pulses_left_next != 14'd0;
  assign res.step_setting  = step_count_next;
  assign res.delay_setting = half_period_next;

  `SPC_ASSERT_NOW(a_no_decode_in_run, cmd.code == CMD_NONE || !run_active,
                  "frame decoded during a pulse run")
  `SPC_ASSERT_NOW(a_high_phase_pin, !pulse_phase || pin_state,
                  "pin low during high half period")
  `SPC_ASSERT_NEXT(a_run_holds, run_active && !(step && action == ACT_TICK),
                   pulses_left == $past(pulses_left), "pulse count moved without a tick")

endmodule

// File: rtl/uart_step_pulse_commander_unit.sv
// Step pulse commander top level: input and result registers, timeout register.
// Depends on spc_pkg, spc_frame and spc_pulse.
//
// Usage
//   Input channel (in_valid/in_stall): action 0 carries one received UART byte
//   in rx_byte, action 1 is one millisecond tick. Each input transaction yields
//   exactly one result transaction on the output channel (out_valid/out_stall)
//   carrying pin level, reply code, busy flag and both stored settings.
//   Configuration channel (cfg_valid/cfg_ready/cfg_data) writes the frame
//   timeout in ticks; cfg_ready is always high. Write it only while idle.
// Flow and throughput
//   An item is captured in the input register and processed in a single pass
//   into the result register, which raises out_valid. One item per cycle is
//   sustained while out_stall holds no waiting result; the per-item state
//   update is one pass of frame compare, digit conversion and phase counter logic.
// Reset
//   Synchronous: both registers empty, timeout 1000, step count 9, half period
//   100, no run, pin low, no partial frame.
// Stall
//   While out_stall holds a waiting result, the input register holds its item
//   and in_stall rises once that register is full.
module uart_step_pulse_commander_unit
  import spc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        pin_level,
  output logic [1:0]  reply,
  output logic        busy_res,
  output logic [13:0] step_setting,
  output logic [13:0] delay_setting,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  logic        hold_valid;
  logic        hold_action;
  logic [7:0]  hold_byte;
  logic        advance;
  logic        step;
  logic [15:0] frame_timeout;
  logic        run_active;
  cmd_t        cmd;
  res_t        res;

  assign advance   = !(out_valid && out_stall);
  assign step      = hold_valid && advance;
  assign in_stall  = hold_valid && !advance;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid    <= 1'b0;
      out_valid     <= 1'b0;
      frame_timeout <= TIMEOUT_RESET;
    end else begin
      if (!in_stall) begin
        hold_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= hold_valid;
      end
      if (cfg_valid && cfg_ready) begin
        frame_timeout <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      hold_action <= action;
      hold_byte   <= rx_byte;
    end
    if (step) begin
      pin_level     <= res.pin_level;
      reply         <= res.reply;
      busy_res      <= res.busy;
      step_setting  <= res.step_setting;
      delay_setting <= res.delay_setting;
    end
  end

  spc_frame u_frame (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .action        (hold_action),
    .rx_byte       (hold_byte),
    .run_active    (run_active),
    .frame_timeout (frame_timeout),
    .cmd           (cmd)
  );

  spc_pulse u_pulse (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .action     (hold_action),
    .cmd        (cmd),
    .run_active (run_active),
    .res        (res)
  );

endmodule
